@@ src/cdr_pkg.sv @@
package cdr_pkg;

    localparam int unsigned IN_BITS  = 40;
    localparam int unsigned OUT_BITS = 120;

    localparam logic [1:0] OP_READ     = 2'd0;
    localparam logic [1:0] OP_WRITE    = 2'd1;
    localparam logic [1:0] OP_DMA_DONE = 2'd2;

    localparam logic [3:0] REG_DRAM_ADDR    = 4'd0;
    localparam logic [3:0] REG_CART_ADDR    = 4'd1;
    localparam logic [3:0] REG_RD_LEN       = 4'd2;
    localparam logic [3:0] REG_WR_LEN       = 4'd3;
    localparam logic [3:0] REG_STATUS       = 4'd4;
    localparam logic [3:0] REG_DOMAIN_FIRST = 4'd5;
    localparam logic [3:0] REG_DOMAIN_LAST  = 4'd12;

    localparam logic [1:0] START_NONE    = 2'd0;
    localparam logic [1:0] START_TO_CART = 2'd1;
    localparam logic [1:0] START_TO_DRAM = 2'd2;

    localparam logic [31:0] FLASH_BASE    = 32'h0800_0000;
    localparam logic [15:0] FLASH_HI      = 16'h0800;
    localparam int unsigned IRQ_CLEAR_BIT = 1;

    typedef struct packed {
        logic        bad_register;
        logic        interrupt;
        logic [24:0] dma_length;
        logic [31:0] dma_cart_addr;
        logic [22:0] dma_dram_addr;
        logic [1:0]  dma_start;
        logic [31:0] read_data;
    } t_result;

endpackage

@@ src/cdr_core.sv @@
module cdr_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic            i_cfg_wr_data,
    input  logic            i_en,
    input  logic [1:0]      i_opcode,
    input  logic [3:0]      i_reg_index,
    input  logic [31:0]     i_write_data,
    output cdr_pkg::t_result o_result
);
    import cdr_pkg::*;

    logic        r_flash, n_flash;
    logic [31:0] r_dram, n_dram;
    logic [31:0] r_cart, n_cart;
    logic [24:0] r_rd_len, n_rd_len;
    logic [24:0] r_wr_len, n_wr_len;
    logic [7:0]  r_domain [8];
    logic [7:0]  n_domain [8];
    logic        r_busy, n_busy;
    logic        r_irq, n_irq;

    logic [22:0] dram_m;
    logic [31:0] cart_e;
    logic [31:0] cart_remap;
    logic [31:0] start_cart;
    logic [24:0] len_raw;
    logic [24:0] len;
    logic [2:0]  mis;
    logic [3:0]  dom_off;
    logic [2:0]  dom_idx;
    logic        is_domain;
    logic        to_dram;
    t_result     res;

    assign dram_m     = {r_dram[22:1], 1'b0};
    assign cart_e     = {r_cart[31:1], 1'b0};
    assign cart_remap = FLASH_BASE | {11'd0, cart_e[19:0], 1'b0};
    assign len_raw    = {1'b0, i_write_data[23:0]} + 25'd1;
    assign mis        = {r_dram[2:1], 1'b0};
    assign len        = (mis != 3'd0 && len_raw >= 25'd7) ? len_raw - {22'd0, mis} : len_raw;
    assign dom_off    = i_reg_index - REG_DOMAIN_FIRST;
    assign dom_idx    = dom_off[2:0];
    assign is_domain  = i_reg_index >= REG_DOMAIN_FIRST && i_reg_index <= REG_DOMAIN_LAST;
    assign to_dram    = i_reg_index == REG_WR_LEN;
    assign start_cart = (to_dram && r_flash && cart_e[31:16] == FLASH_HI) ? cart_remap : cart_e;

    always_comb begin
        n_flash  = i_cfg_wr_en ? i_cfg_wr_data : r_flash;
        n_dram   = r_dram;
        n_cart   = r_cart;
        n_rd_len = r_rd_len;
        n_wr_len = r_wr_len;
        n_domain = r_domain;
        n_busy   = r_busy;
        n_irq    = r_irq;
        res      = '0;
        case (i_opcode)
            OP_READ: begin
                case (i_reg_index)
                    REG_DRAM_ADDR: res.read_data = r_dram;
                    REG_CART_ADDR: res.read_data = r_cart;
                    REG_RD_LEN:    res.read_data = {7'd0, r_rd_len};
                    REG_WR_LEN:    res.read_data = {7'd0, r_wr_len};
                    REG_STATUS:    res.read_data = {28'd0, r_irq, 2'd0, r_busy};
                    default: begin
                        if (is_domain) begin
                            res.read_data = {24'd0, r_domain[dom_idx]};
                        end else begin
                            res.bad_register = 1'b1;
                        end
                    end
                endcase
            end
            OP_WRITE: begin
                case (i_reg_index)
                    REG_DRAM_ADDR: n_dram = i_write_data;
                    REG_CART_ADDR: n_cart = i_write_data;
                    REG_RD_LEN, REG_WR_LEN: begin
                        if (to_dram) begin
                            n_wr_len = len;
                        end else begin
                            n_rd_len = len;
                        end
                        n_busy            = 1'b1;
                        res.dma_start     = to_dram ? START_TO_DRAM : START_TO_CART;
                        res.dma_dram_addr = dram_m;
                        res.dma_cart_addr = start_cart;
                        res.dma_length    = len;
                        n_dram            = {9'd0, dram_m} + {7'd0, len};
                        n_cart            = start_cart + {7'd0, len};
                    end
                    REG_STATUS: begin
                        if (i_write_data[IRQ_CLEAR_BIT]) begin
                            n_irq = 1'b0;
                        end
                    end
                    default: begin
                        if (is_domain) begin
                            n_domain[dom_idx] = i_write_data[7:0];
                        end else begin
                            res.bad_register = 1'b1;
                        end
                    end
                endcase
            end
            OP_DMA_DONE: begin
                n_irq  = 1'b1;
                n_busy = 1'b0;
            end
            default: ;
        endcase
        res.interrupt = n_irq;
        if (!i_en) begin
            n_dram   = r_dram;
            n_cart   = r_cart;
            n_rd_len = r_rd_len;
            n_wr_len = r_wr_len;
            n_domain = r_domain;
            n_busy   = r_busy;
            n_irq    = r_irq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash  <= 1'b0;
            r_dram   <= '0;
            r_cart   <= '0;
            r_rd_len <= '0;
            r_wr_len <= '0;
            r_domain <= '{default: 8'd0};
            r_busy   <= 1'b0;
            r_irq    <= 1'b0;
        end else begin
            r_flash  <= n_flash;
            r_dram   <= n_dram;
            r_cart   <= n_cart;
            r_rd_len <= n_rd_len;
            r_wr_len <= n_wr_len;
            r_domain <= n_domain;
            r_busy   <= n_busy;
            r_irq    <= n_irq;
        end
    end

    assign o_result = res;

    a_start_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && res.dma_start != START_NONE |=> r_busy)
        else $error("busy not set after start");

    a_done_sets_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_opcode == OP_DMA_DONE |=> r_irq && !r_busy)
        else $error("completion did not raise irq");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_dram) && $stable(r_cart) && $stable(r_irq))
        else $error("state changed without an item");

endmodule

@@ src/cart_dma_register_block.sv @@
// channel   | dir | fields (lsb first)
// s_axis    | in  | tdata: opcode[1:0] reg_index[5:2] write_data[37:6]
// m_axis    | out | tdata: read_data dma_start dma_dram_addr dma_cart_addr
//           |     |        dma_length interrupt bad_register
// cfg       | in  | i_cfg_wr_en, i_cfg_wr_data = flash_save
// one word per cycle while m_axis is not stalled; each word passes the input register then the result register
// register state updates as a word moves from the input to the result register
// synchronous active-low reset clears state, flash_save and both valid flags
// a stalled m_axis holds both stages; s_axis stalls only when both are full
module cart_dma_register_block (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic                           i_cfg_wr_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // opcode, reg_index, write_data, zero pad
    input  logic [cdr_pkg::IN_BITS-1:0]    s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // read_data, dma_start, dma_dram_addr, dma_cart_addr, dma_length,
    // interrupt, bad_register, zero pad
    output logic [cdr_pkg::OUT_BITS-1:0]   m_axis_tdata
);
    import cdr_pkg::*;

    logic        r_in_valid;
    logic [37:0] r_in_data;
    logic        r_out_valid;
    t_result     r_out;
    t_result     res;
    logic        adv;

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    cdr_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_en          (adv),
        .i_opcode      (r_in_data[1:0]),
        .i_reg_index   (r_in_data[5:2]),
        .i_write_data  (r_in_data[37:6]),
        .o_result      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata[37:0];
        end
        if (adv) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out};

    a_no_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.dma_start == START_NONE |->
            r_out.dma_length == 25'd0 && r_out.dma_cart_addr == 32'd0)
        else $error("transfer fields without a start");

    a_start_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.dma_start != START_NONE |->
            r_out.dma_length != 25'd0 && !r_out.dma_cart_addr[0] && !r_out.dma_dram_addr[0])
        else $error("malformed transfer description");

    a_bad_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.bad_register |->
            r_out.dma_start == START_NONE && r_out.read_data == 32'd0)
        else $error("bad register access had an effect");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && r_out_valid && !m_axis_tready)
        else $error("input stalled with room free");

endmodule
